/* rtl/core/ffba_pkg.sv */
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int REQ_W  = 27;
    localparam int ADDR_W = 32;
    localparam int BYTES_W = 33;
    localparam int STAT_W = 3;
    localparam int CNT_OUT_W = 7;
    localparam int META_W = 12;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_REALLOC = 2'd2;
    localparam logic [1:0] CMD_CALLOC  = 2'd3;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE     = 3'd1;
    localparam logic [2:0] ST_NO_MEMORY    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN      = 3'd3;
    localparam logic [2:0] ST_ALREADY_FREE = 3'd4;

    localparam logic [1:0] CFG_HEAP_BASE   = 2'd0;
    localparam logic [1:0] CFG_HEAP_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_MAX_REQUEST = 2'd2;

    localparam logic [REQ_W-1:0] MAX_REQUEST_RESET = 27'd100000000;
    localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

    typedef struct packed {
        logic       latch;
        logic       mul;
        logic       scan_clear;
        logic       scan_step;
        logic       rd;
        logic       save_hit;
        logic       take;
        logic       append;
        logic       free_hit;
        logic       keep;
        logic       set_status;
        logic [2:0] status_code;
        logic       load_out;
    } ffba_ctl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       size_bad;
        logic       addr_zero;
        logic       scan_done;
        logic       match;
        logic       rd_free;
        logic       in_place;
        logic       fit;
        logic       grow_fail;
        logic       out_free;
    } ffba_sts_t;

endpackage

/* rtl/core/ffba_ctrl.sv */
`timescale 1ns / 1ps

module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ffba_sts_t sts,
    output ffba_ctl_t ctl
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MUL      = 4'd1;
    localparam logic [3:0] S_CHECK    = 4'd2;
    localparam logic [3:0] S_FIND_RD  = 4'd3;
    localparam logic [3:0] S_FIND_EV  = 4'd4;
    localparam logic [3:0] S_FIT_RD   = 4'd5;
    localparam logic [3:0] S_FIT_EV   = 4'd6;
    localparam logic [3:0] S_GROW     = 4'd7;
    localparam logic [3:0] S_FREE_OLD = 4'd8;
    localparam logic [3:0] S_OUT      = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       move_reg;
    logic       move_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        move_next  = move_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.latch  = 1'b1;
                    move_next  = 1'b0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                ctl.scan_clear = 1'b1;
                if (sts.cmd == CMD_FREE)
                begin
                    state_next = sts.addr_zero ? S_OUT : S_FIND_RD;
                end
                else if (sts.size_bad)
                begin
                    ctl.set_status  = 1'b1;
                    ctl.status_code = ST_BAD_SIZE;
                    state_next      = S_OUT;
                end
                else if (sts.cmd == CMD_REALLOC && !sts.addr_zero)
                begin
                    state_next = S_FIND_RD;
                end
                else
                begin
                    state_next = S_FIT_RD;
                end
            end
            S_FIND_RD:
            begin
                if (sts.scan_done)
                begin
                    ctl.set_status  = 1'b1;
                    ctl.status_code = ST_UNKNOWN;
                    state_next      = S_OUT;
                end
                else
                begin
                    ctl.rd     = 1'b1;
                    state_next = S_FIND_EV;
                end
            end
            S_FIND_EV:
            begin
                if (sts.match)
                begin
                    ctl.save_hit = 1'b1;
                    if (sts.rd_free)
                    begin
                        ctl.set_status  = 1'b1;
                        ctl.status_code = ST_ALREADY_FREE;
                        state_next      = S_OUT;
                    end
                    else if (sts.cmd == CMD_FREE)
                    begin
                        state_next = S_FREE_OLD;
                    end
                    else if (sts.in_place)
                    begin
                        ctl.keep   = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        move_next      = 1'b1;
                        ctl.scan_clear = 1'b1;
                        state_next     = S_FIT_RD;
                    end
                end
                else
                begin
                    ctl.scan_step = 1'b1;
                    state_next    = S_FIND_RD;
                end
            end
            S_FIT_RD:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_GROW;
                end
                else
                begin
                    ctl.rd     = 1'b1;
                    state_next = S_FIT_EV;
                end
            end
            S_FIT_EV:
            begin
                if (sts.fit)
                begin
                    ctl.take   = 1'b1;
                    state_next = move_reg ? S_FREE_OLD : S_OUT;
                end
                else
                begin
                    ctl.scan_step = 1'b1;
                    state_next    = S_FIT_RD;
                end
            end
            S_GROW:
            begin
                if (sts.grow_fail)
                begin
                    ctl.set_status  = 1'b1;
                    ctl.status_code = ST_NO_MEMORY;
                    state_next      = S_OUT;
                end
                else
                begin
                    ctl.append = 1'b1;
                    state_next = move_reg ? S_FREE_OLD : S_OUT;
                end
            end
            S_FREE_OLD:
            begin
                ctl.free_hit = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            move_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            move_reg  <= move_next;
        end
    end

endmodule

/* rtl/core/ffba_dp.sv */
`timescale 1ns / 1ps

module ffba_dp
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [87:0]  in_data,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  ffba_ctl_t    ctl,
    output ffba_sts_t    sts,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [127:0] out_data
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_BLOCKS);
    localparam logic [ADDR_W-1:0] HDR = ADDR_W'(HEADER_BYTES);

    logic [ADDR_W-1:0] mem_off   [MAX_BLOCKS];
    logic [REQ_W-1:0]  mem_bytes [MAX_BLOCKS];
    logic              mem_free  [MAX_BLOCKS];

    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] limit_reg;
    logic [REQ_W-1:0]  maxreq_reg;

    logic [1:0]        cmd_reg;
    logic [REQ_W-1:0]  size_reg;
    logic [REQ_W-1:0]  count_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [2*REQ_W-1:0] prod_reg;
    logic [ADDR_W+1:0] end_reg;

    logic [CW-1:0]     scan_reg;
    logic [ADDR_W-1:0] rd_off_reg;
    logic [REQ_W-1:0]  rd_bytes_reg;
    logic              rd_free_reg;
    logic [IW-1:0]     hit_idx_reg;
    logic [REQ_W-1:0]  hit_bytes_reg;

    logic [CW-1:0]      total_reg;
    logic [CW-1:0]      free_cnt_reg;
    logic [ADDR_W-1:0]  brk_reg;
    logic [BYTES_W-1:0] free_bytes_reg;
    logic [BYTES_W-1:0] created_reg;

    logic [ADDR_W-1:0] res_reg;
    logic [2:0]        status_reg;
    logic              out_valid_reg;
    logic [127:0]      out_data_reg;

    logic [REQ_W-1:0]   req;
    logic [ADDR_W-1:0]  rd_payload;
    logic [BYTES_W:0]   free_sum;
    logic [BYTES_W:0]   created_sum;
    logic [BYTES_W-1:0] free_sub;
    logic [6:0]         blocks_sat;
    logic [6:0]         free_blocks_sat;
    logic [31:0]        meta_full;
    logic [11:0]        meta_sat;
    logic               size_bad;

    assign req        = (cmd_reg == CMD_CALLOC) ? prod_reg[REQ_W-1:0] : size_reg;
    assign rd_payload = base_reg + rd_off_reg + HDR;

    always_comb
    begin
        if (cmd_reg == CMD_CALLOC)
        begin
            size_bad = (size_reg == '0) || (count_reg == '0) ||
                       (prod_reg > {{REQ_W{1'b0}}, maxreq_reg});
        end
        else
        begin
            size_bad = (size_reg == '0) || (size_reg > maxreq_reg);
        end
    end

    assign sts.cmd       = cmd_reg;
    assign sts.size_bad  = size_bad;
    assign sts.addr_zero = (addr_reg == '0);
    assign sts.scan_done = (scan_reg >= total_reg);
    assign sts.match     = (rd_payload == addr_reg);
    assign sts.rd_free   = rd_free_reg;
    assign sts.in_place  = (req <= rd_bytes_reg);
    assign sts.fit       = rd_free_reg && (rd_bytes_reg >= req);
    assign sts.grow_fail = (total_reg >= CNT_FULL) || (end_reg > {2'b00, limit_reg});
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign free_sum    = {1'b0, free_bytes_reg} + {{(BYTES_W + 1 - REQ_W){1'b0}}, hit_bytes_reg};
    assign created_sum = {1'b0, created_reg} + {{(BYTES_W + 1 - REQ_W){1'b0}}, req};
    assign free_sub    = (free_bytes_reg > BYTES_W'(rd_bytes_reg)) ?
                         free_bytes_reg - BYTES_W'(rd_bytes_reg) : '0;

    assign blocks_sat      = (32'(total_reg) > 32'd127) ? 7'd127 : 7'(total_reg);
    assign free_blocks_sat = (32'(free_cnt_reg) > 32'd127) ? 7'd127 : 7'(free_cnt_reg);
    assign meta_full       = 32'(total_reg) * 32'(HEADER_BYTES);
    assign meta_sat        = (meta_full > 32'd4095) ? 12'd4095 : meta_full[11:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            limit_reg  <= '1;
            maxreq_reg <= MAX_REQUEST_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEAP_BASE:   base_reg   <= cfg_data;
                CFG_HEAP_LIMIT:  limit_reg  <= cfg_data;
                CFG_MAX_REQUEST: maxreq_reg <= cfg_data[REQ_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg   <= in_data[1:0];
            size_reg  <= in_data[28:2];
            count_reg <= in_data[55:29];
            addr_reg  <= in_data[87:56];
        end
        if (ctl.mul)
        begin
            prod_reg <= size_reg * count_reg;
        end
        end_reg <= {2'b00, base_reg} + {2'b00, brk_reg} + {2'b00, HDR}
                   + {{(ADDR_W + 2 - REQ_W){1'b0}}, req};
        if (ctl.rd)
        begin
            rd_off_reg   <= mem_off[scan_reg[IW-1:0]];
            rd_bytes_reg <= mem_bytes[scan_reg[IW-1:0]];
            rd_free_reg  <= mem_free[scan_reg[IW-1:0]];
        end
        if (ctl.save_hit)
        begin
            hit_idx_reg   <= scan_reg[IW-1:0];
            hit_bytes_reg <= rd_bytes_reg;
        end
        if (ctl.append)
        begin
            mem_off[total_reg[IW-1:0]]   <= brk_reg;
            mem_bytes[total_reg[IW-1:0]] <= req;
            mem_free[total_reg[IW-1:0]]  <= 1'b0;
        end
        else if (ctl.take)
        begin
            mem_free[scan_reg[IW-1:0]] <= 1'b0;
        end
        else if (ctl.free_hit)
        begin
            mem_free[hit_idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg       <= '0;
            total_reg      <= '0;
            free_cnt_reg   <= '0;
            brk_reg        <= '0;
            free_bytes_reg <= '0;
            created_reg    <= '0;
            res_reg        <= '0;
            status_reg     <= ST_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.scan_clear)
            begin
                scan_reg <= '0;
            end
            else if (ctl.scan_step)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (ctl.latch)
            begin
                res_reg    <= '0;
                status_reg <= ST_OK;
            end
            if (ctl.set_status)
            begin
                status_reg <= ctl.status_code;
            end
            if (ctl.keep)
            begin
                res_reg <= addr_reg;
            end
            if (ctl.take)
            begin
                res_reg        <= rd_payload;
                free_bytes_reg <= free_sub;
                if (free_cnt_reg != '0)
                begin
                    free_cnt_reg <= free_cnt_reg - 1'b1;
                end
            end
            if (ctl.append)
            begin
                res_reg     <= base_reg + brk_reg + HDR;
                total_reg   <= total_reg + 1'b1;
                brk_reg     <= brk_reg + HDR + ADDR_W'(req);
                created_reg <= created_sum[BYTES_W] ? BYTES_MAX : created_sum[BYTES_W-1:0];
            end
            if (ctl.free_hit)
            begin
                free_cnt_reg   <= free_cnt_reg + 1'b1;
                free_bytes_reg <= free_sum[BYTES_W] ? BYTES_MAX : free_sum[BYTES_W-1:0];
            end
            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            out_data_reg <= {1'b0, meta_sat, created_reg, blocks_sat, free_bytes_reg,
                             free_blocks_sat, status_reg, res_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/core/first_fit_block_allocator.sv */
`timescale 1ns / 1ps
// First-fit block allocator without splitting, over a table of up to MAX_BLOCKS blocks.
// The s_ channel takes one command item (alloc, free, realloc, calloc); the m_ channel
// returns exactly one result item per command, carrying the address, a status code and
// the statistics counters as they stand after the command.
// Configuration registers (heap base, heap limit, largest request) are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while no command is in
// flight, as the block does not enforce it. One command is worked on at a time.
// Each table entry walked is read from the block table and then evaluated.
// Alloc and free walk at most N entries (N blocks in the table); a realloc that moves
// walks up to 2N entries.
// The result sits in an output register; the next command is accepted while it waits.
// If the receiver stalls, a finished second result holds the block until the first is
// taken. Reset empties the table, clears the counters and restores the register defaults.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd, request_size, elem_count, address
    input  logic [87:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_address, status, free_blocks, free_bytes, allocated_blocks,
    // allocated_bytes, metadata_bytes, zero pad
    output logic [127:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    ffba_ctl_t ctl;
    ffba_sts_t sts;

    ffba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    ffba_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

/* rtl/core/ffba_checker.sv */
`timescale 1ns / 1ps

module ffba_checker
    import ffba_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[34:32] <= ST_ALREADY_FREE)
        else $error("status code out of range");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[34:32] != ST_OK |-> m_tdata[31:0] == 32'd0)
        else $error("failed command returned an address");

    a_free_le: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[41:35] <= m_tdata[81:75])
        else $error("more free blocks than blocks");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/first_fit_block_allocator_checker.sv */
`timescale 1ns / 1ps

module first_fit_block_allocator_checker
    import ffba_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [87:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output int           mismatches,
    output int           pending
);

    localparam int DEPTH = 64;
    localparam int HDR = 32;

    typedef struct {
        logic [ADDR_W-1:0]    addr;
        logic [STAT_W-1:0]    status;
        logic [CNT_OUT_W-1:0] free_blocks;
        logic [BYTES_W-1:0]   free_bytes;
        logic [CNT_OUT_W-1:0] blocks;
        logic [BYTES_W-1:0]   created_bytes;
        logic [META_W-1:0]    meta;
    } heap_result_t;

    heap_result_t expected_results[$];

    logic [31:0] base_q;
    logic [31:0] limit_q;
    logic [26:0] max_req_q;
    logic [31:0] blk_off[DEPTH];
    logic [26:0] blk_size[DEPTH];
    logic        blk_free[DEPTH];
    int          blk_count;
    logic [31:0] brk;
    int          free_count;
    logic [63:0] free_total;
    logic [63:0] created_total;

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > 64'h1_FFFF_FFFF) ? 64'h1_FFFF_FFFF : s;
    endfunction

    function automatic logic [31:0] payload_of(int i);
        logic [63:0] a;
        a = {32'd0, base_q} + {32'd0, blk_off[i]} + HDR;
        return a[31:0];
    endfunction

    function automatic int lookup(logic [31:0] a);
        for (int i = 0; i < blk_count; i++)
            if (payload_of(i) == a)
                return i;
        return -1;
    endfunction

    function automatic logic size_valid(logic [63:0] sz);
        return sz != 0 && sz <= {37'd0, max_req_q};
    endfunction

    function automatic void mark_free(int i);
        blk_free[i] = 1'b1;
        free_count++;
        free_total = sat_sum(free_total, {37'd0, blk_size[i]});
    endfunction

    function automatic logic [2:0] place(logic [63:0] sz, output logic [31:0] a);
        logic [63:0] top;
        a = '0;
        for (int i = 0; i < blk_count; i++)
        begin
            if (blk_free[i] && {37'd0, blk_size[i]} >= sz)
            begin
                blk_free[i] = 1'b0;
                if (free_count > 0)
                    free_count--;
                free_total = (free_total > blk_size[i]) ? free_total - blk_size[i] : 64'd0;
                a = payload_of(i);
                return ST_OK;
            end
        end
        if (blk_count >= DEPTH)
            return ST_NO_MEMORY;
        top = {32'd0, base_q} + {32'd0, brk} + HDR + sz;
        if (top > {32'd0, limit_q})
            return ST_NO_MEMORY;
        blk_off[blk_count] = brk;
        blk_size[blk_count] = sz[26:0];
        blk_free[blk_count] = 1'b0;
        a = payload_of(blk_count);
        blk_count++;
        brk = brk + HDR + sz[31:0];
        created_total = sat_sum(created_total, sz);
        return ST_OK;
    endfunction

    function automatic heap_result_t heap_step(logic [87:0] item);
        heap_result_t r;
        logic [1:0]  cmd;
        logic [63:0] sz;
        logic [63:0] cnt;
        logic [31:0] a_in;
        logic [31:0] res;
        logic [2:0]  st;
        logic [63:0] meta;
        int          idx;
        cmd = item[1:0];
        sz = {37'd0, item[28:2]};
        cnt = {37'd0, item[55:29]};
        a_in = item[87:56];
        res = '0;
        st = ST_OK;
        case (cmd)
            CMD_ALLOC:
                st = size_valid(sz) ? place(sz, res) : ST_BAD_SIZE;
            CMD_CALLOC:
                if (sz == 0 || cnt == 0 || !size_valid(sz * cnt))
                    st = ST_BAD_SIZE;
                else
                    st = place(sz * cnt, res);
            CMD_FREE:
                if (a_in != 0)
                begin
                    idx = lookup(a_in);
                    if (idx < 0)
                        st = ST_UNKNOWN;
                    else if (blk_free[idx])
                        st = ST_ALREADY_FREE;
                    else
                        mark_free(idx);
                end
            default:
                if (!size_valid(sz))
                    st = ST_BAD_SIZE;
                else if (a_in == 0)
                    st = place(sz, res);
                else
                begin
                    idx = lookup(a_in);
                    if (idx < 0)
                        st = ST_UNKNOWN;
                    else if (blk_free[idx])
                        st = ST_ALREADY_FREE;
                    else if (sz <= blk_size[idx])
                        res = a_in;
                    else
                    begin
                        st = place(sz, res);
                        if (st == ST_OK)
                            mark_free(idx);
                    end
                end
        endcase
        meta = blk_count * HDR;
        r.addr = res;
        r.status = st;
        r.free_blocks = (free_count > 127) ? 7'd127 : free_count[6:0];
        r.free_bytes = free_total[32:0];
        r.blocks = (blk_count > 127) ? 7'd127 : blk_count[6:0];
        r.created_bytes = created_total[32:0];
        r.meta = (meta > 4095) ? 12'd4095 : meta[11:0];
        return r;
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, name, want, want, got, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        heap_result_t w;
        if (!rst_n)
        begin
            base_q = '0;
            limit_q = 32'hFFFF_FFFF;
            max_req_q = MAX_REQUEST_RESET;
            for (int i = 0; i < DEPTH; i++)
            begin
                blk_off[i] = '0;
                blk_size[i] = '0;
                blk_free[i] = 1'b0;
            end
            blk_count = 0;
            brk = '0;
            free_count = 0;
            free_total = '0;
            created_total = '0;
            expected_results.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HEAP_BASE:   base_q = cfg_data;
                    CFG_HEAP_LIMIT:  limit_q = cfg_data;
                    CFG_MAX_REQUEST: max_req_q = cfg_data[26:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(heap_step(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result item with none expected, actual 0x%0h",
                             $time, m_tdata);
                end
                else
                begin
                    w = expected_results.pop_front();
                    compare_field("result_address", w.addr, m_tdata[31:0]);
                    compare_field("status", w.status, m_tdata[34:32]);
                    compare_field("free_blocks", w.free_blocks, m_tdata[41:35]);
                    compare_field("free_bytes", w.free_bytes, m_tdata[74:42]);
                    compare_field("allocated_blocks", w.blocks, m_tdata[81:75]);
                    compare_field("allocated_bytes", w.created_bytes, m_tdata[114:82]);
                    compare_field("metadata_bytes", w.meta, m_tdata[126:115]);
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

/* tb/first_fit_block_allocator_test.sv */
`timescale 1ns / 1ps

module first_fit_block_allocator_test;
    import ffba_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [87:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;
    int           mismatches;
    int           pending;

    logic [31:0]  live_addrs[$];
    logic [26:0]  cur_max_req;
    logic         quiet;
    logic         hold_req;
    int           items_sent;
    int           settings_used;

    first_fit_block_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    first_fit_block_allocator_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    // Addresses handed out are recycled as free and realloc targets.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready && m_tdata[34:32] == ST_OK && m_tdata[31:0] != 0)
        begin
            live_addrs.push_back(m_tdata[31:0]);
            if (live_addrs.size() > 96)
                void'(live_addrs.pop_front());
        end
    end

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (quiet)
                m_tready <= 1'b1;
            else if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge clk);
            end
        end
    end

    task automatic send_cmd(logic [1:0] cmd, logic [26:0] size, logic [26:0] count,
                            logic [31:0] addr);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {addr, count, size, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13) - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(logic [31:0] base, logic [31:0] limit, logic [26:0] max_req);
        drain();
        write_reg(CFG_HEAP_BASE, base);
        write_reg(CFG_HEAP_LIMIT, limit);
        write_reg(CFG_MAX_REQUEST, {5'd0, max_req});
        cur_max_req = max_req;
        live_addrs.delete();
        settings_used++;
    endtask

    function automatic logic [26:0] pick_size();
        int cap;
        cap = (cur_max_req > 3000) ? 3000 : int'(cur_max_req);
        case ($urandom_range(0, 11))
            0: return '0;
            1: return 27'($urandom);
            2: return cur_max_req;
            3: return 27'(cur_max_req + 27'd1);
            default: return 27'($urandom_range(1, cap));
        endcase
    endfunction

    function automatic logic [31:0] pick_addr();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7 && live_addrs.size() > 0)
            return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        else if (r == 7)
            return '0;
        else
            return $urandom;
    endfunction

    task automatic random_items(int n);
        logic [1:0]  cmd;
        logic [26:0] size;
        logic [26:0] count;
        for (int k = 0; k < n; k++)
        begin
            cmd = 2'($urandom_range(0, 3));
            size = pick_size();
            count = 27'($urandom_range(0, 4));
            if (cmd == CMD_CALLOC)
            begin
                size = $urandom_range(0, 9) == 0 ? pick_size() : 27'($urandom_range(0, 64));
                if ($urandom_range(0, 9) == 0)
                    count = 27'($urandom);
            end
            send_cmd(cmd, size, count, pick_addr());
        end
    endtask

    initial
    begin
        logic [31:0] a0;
        logic [31:0] a1;
        logic [31:0] a2;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        items_sent = 0;
        settings_used = 0;
        cur_max_req = MAX_REQUEST_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        apply_setting(32'h0000_1000, 32'hFFFF_FFFF, MAX_REQUEST_RESET);
        a0 = 32'h0000_1020;
        a1 = 32'h0000_1000 + 32'd100000064;
        a2 = a1 + 32'd33;
        send_cmd(CMD_ALLOC, 27'd0, 27'd0, 32'd0);
        send_cmd(CMD_ALLOC, MAX_REQUEST_RESET, 27'd0, 32'd0);
        send_cmd(CMD_ALLOC, 27'd1, 27'd0, 32'd0);
        send_cmd(CMD_CALLOC, 27'd0, 27'd5, 32'd0);
        send_cmd(CMD_CALLOC, 27'd5, 27'd0, 32'd0);
        send_cmd(CMD_CALLOC, 27'd5, 27'd3, 32'd0);
        send_cmd(CMD_CALLOC, 27'h7FF_FFFF, 27'h7FF_FFFF, 32'd0);
        send_cmd(CMD_ALLOC, 27'h7FF_FFFF, 27'd0, 32'd0);
        send_cmd(CMD_FREE, 27'd0, 27'd0, 32'd0);
        send_cmd(CMD_FREE, 27'd0, 27'd0, 32'hFFFF_FFFF);
        send_cmd(CMD_FREE, 27'd0, 27'd0, a0);
        send_cmd(CMD_FREE, 27'd0, 27'd0, a0);
        send_cmd(CMD_REALLOC, 27'd10, 27'd0, a0);
        send_cmd(CMD_ALLOC, 27'd50, 27'd0, 32'd0);
        send_cmd(CMD_REALLOC, 27'd7, 27'd0, 32'd0);
        send_cmd(CMD_REALLOC, 27'd1, 27'd0, a1);
        send_cmd(CMD_REALLOC, 27'd200, 27'd0, a1);
        send_cmd(CMD_REALLOC, 27'd4, 27'd0, 32'h0000_DEAD);
        send_cmd(CMD_REALLOC, 27'd0, 27'd0, a2);

        apply_setting(32'h0000_1000, 32'd0, MAX_REQUEST_RESET);
        send_cmd(CMD_ALLOC, 27'd10, 27'd0, 32'd0);
        send_cmd(CMD_REALLOC, 27'd1000, 27'd0, a2);
        send_cmd(CMD_FREE, 27'd0, 27'd0, a2);
        apply_setting(32'h0000_1000, 32'd0, 27'd1);
        send_cmd(CMD_ALLOC, 27'd2, 27'd0, 32'd0);
        send_cmd(CMD_ALLOC, 27'd1, 27'd0, 32'd0);

        apply_setting(32'h0000_0000, 32'hFFFF_FFFF, MAX_REQUEST_RESET);
        random_items(80);
        hold_req = 1'b1;
        random_items(80);
        apply_setting(32'h0000_0000, 32'h0004_0000, 27'd4096);
        random_items(160);
        apply_setting(32'hFFFF_0000, 32'hFFFF_FFFF, 27'd1);
        random_items(80);
        apply_setting(32'h8000_0000, 32'hFFFF_FFFF, MAX_REQUEST_RESET);
        random_items(120);
        drain();
        quiet = 1'b1;
        random_items(120);

        drain();
        repeat (300) @(posedge clk);
        $display("Ran %0d commands over %0d heap settings, including table-full,",
                 items_sent, settings_used);
        $display("out-of-memory, bad-size, double-free and moved-base cases.");
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/ffba_pkg.sv
rtl/core/ffba_ctrl.sv
rtl/core/ffba_dp.sv
rtl/core/first_fit_block_allocator.sv
rtl/core/ffba_checker.sv
tb/first_fit_block_allocator_checker.sv
tb/first_fit_block_allocator_test.sv
